### hw/rtl/bafp_pkg.sv
// ============================================================================
// bafp_pkg
// Shared widths, angle constants and octant flags for the binary angle block.
// ============================================================================
package bafp_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MAG_W     = COORD_W;
    localparam int QUOT_W    = 22;
    localparam int PROD_W    = QUOT_W + MAG_W;
    localparam int RATIO_LSB = 16;
    localparam int RATIO_W   = 6;
    localparam int DIR_W     = 8;

    localparam int DIV_BPS_DEFAULT = 2;

    localparam logic [DIR_W-1:0] DIR_UP        = 8'h00;
    localparam logic [DIR_W-1:0] DIR_RIGHT     = 8'h40;
    localparam logic [DIR_W-1:0] DIR_DOWN      = 8'h80;
    localparam logic [DIR_W-1:0] DIR_LEFT      = 8'hC0;
    localparam logic [DIR_W-1:0] BASE_RD_STEEP = 8'h7F;
    localparam logic [DIR_W-1:0] BASE_RD_FLAT  = 8'h3F;
    localparam logic [DIR_W-1:0] BASE_LU_STEEP = 8'hFF;
    localparam logic [DIR_W-1:0] BASE_LU_FLAT  = 8'h41;

    typedef struct packed {
        logic dx_zero;
        logic dy_zero;
        logic dx_neg;
        logic dy_neg;
        logic steep;
    } oct_t;

    localparam int SIDE_W = MAG_W + $bits(oct_t);

endpackage

### hw/rtl/binary_angle_from_points.sv
// ============================================================================
// binary_angle_from_points
// Direction from one point to another as an 8-bit binary angle.
// ============================================================================
// Input words carry two signed 16-bit points (from, to) on s_axis; each gives
// one output word on m_axis holding the angle: 0 up, 0x40 right, 0x80 down,
// 0xC0 left, 256 steps per turn.
// Pipeline: difference, magnitude and octant, a restoring divider forming
// 0x200000 / larger at DIV_BITS_PER_STAGE quotient bits per stage, multiply
// by the smaller magnitude, then the octant base add.
// Throughput: one word per cycle while m_axis is ready; the divider stages set the latency.
// Every stage has its own valid bit and takes a new word when it is empty or
// its successor moves, so bubbles close up and a word is accepted while a
// finished result waits on m_axis.
// A stall on m_axis holds every full stage that has no empty stage after it; nothing is dropped or repeated.
// Reset clears all valid bits; the data registers are not reset.
// ============================================================================
module binary_angle_from_points #(
    parameter int DIV_BITS_PER_STAGE = bafp_pkg::DIV_BPS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // from_x, from_y, to_x, to_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // direction
);

    import bafp_pkg::*;

    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;

    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              v4_reg;
    logic              rdy1;
    logic              rdy2;
    logic              rdy3;
    logic              rdy4;

    logic [DIFF_W-1:0] dx_reg;
    logic [DIFF_W-1:0] dy_reg;
    logic [DIFF_W-1:0] dx_next;
    logic [DIFF_W-1:0] dy_next;

    logic [DIFF_W-1:0] ax_full;
    logic [DIFF_W-1:0] ay_full;
    logic [MAG_W-1:0]  ax;
    logic [MAG_W-1:0]  ay;
    oct_t              oct_next;
    logic [MAG_W-1:0]  larger_next;
    logic [MAG_W-1:0]  smaller_next;
    logic [MAG_W-1:0]  larger_reg;
    logic [MAG_W-1:0]  smaller_reg;
    oct_t              oct2_reg;

    logic              div_in_ready;
    logic              div_out_valid;
    logic [QUOT_W-1:0] div_quot;
    logic [SIDE_W-1:0] div_side;
    logic [MAG_W-1:0]  div_smaller;
    oct_t              div_oct;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    oct_t              oct3_reg;

    logic [RATIO_W-1:0] ratio;
    logic [DIR_W-1:0]   r8;
    logic [DIR_W-1:0]   dir_next;
    logic [DIR_W-1:0]   dir_reg;

    assign from_x = s_axis_tdata[15:0];
    assign from_y = s_axis_tdata[31:16];
    assign to_x   = s_axis_tdata[47:32];
    assign to_y   = s_axis_tdata[63:48];

    assign rdy4          = !v4_reg || m_axis_tready;
    assign rdy3          = !v3_reg || rdy4;
    assign rdy2          = !v2_reg || div_in_ready;
    assign rdy1          = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    assign dx_next = {to_x[COORD_W-1], to_x} - {from_x[COORD_W-1], from_x};
    assign dy_next = {to_y[COORD_W-1], to_y} - {from_y[COORD_W-1], from_y};

    assign ax_full = dx_reg[DIFF_W-1] ? (~dx_reg + 1'b1) : dx_reg;
    assign ay_full = dy_reg[DIFF_W-1] ? (~dy_reg + 1'b1) : dy_reg;
    assign ax      = ax_full[MAG_W-1:0];
    assign ay      = ay_full[MAG_W-1:0];

    always_comb
    begin
        oct_next.dx_zero = (dx_reg == '0);
        oct_next.dy_zero = (dy_reg == '0);
        oct_next.dx_neg  = dx_reg[DIFF_W-1];
        oct_next.dy_neg  = dy_reg[DIFF_W-1];
        oct_next.steep   = (ax <= ay);
        larger_next      = oct_next.steep ? ay : ax;
        smaller_next     = oct_next.steep ? ax : ay;
    end

    bafp_div #(
        .BITS_PER_STAGE (DIV_BITS_PER_STAGE),
        .SIDE_W         (SIDE_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v2_reg),
        .in_ready   (div_in_ready),
        .in_divisor (larger_reg),
        .in_side    ({smaller_reg, oct2_reg}),
        .out_valid  (div_out_valid),
        .out_ready  (rdy3),
        .out_quot   (div_quot),
        .out_side   (div_side)
    );

    assign div_smaller = div_side[SIDE_W-1 -: MAG_W];
    assign div_oct     = oct_t'(div_side[$bits(oct_t)-1:0]);

    assign prod_next = PROD_W'(div_quot) * PROD_W'(div_smaller);

    assign ratio = prod_reg[RATIO_LSB +: RATIO_W];
    assign r8    = DIR_W'(ratio);

    always_comb
    begin
        if (oct3_reg.dx_zero && oct3_reg.dy_zero)
        begin
            dir_next = DIR_UP;
        end
        else if (oct3_reg.dx_zero)
        begin
            dir_next = oct3_reg.dy_neg ? DIR_UP : DIR_DOWN;
        end
        else if (oct3_reg.dy_zero)
        begin
            dir_next = oct3_reg.dx_neg ? DIR_LEFT : DIR_RIGHT;
        end
        else if (!oct3_reg.dx_neg && oct3_reg.dy_neg)
        begin
            dir_next = oct3_reg.steep ? r8 : DIR_RIGHT - r8;
        end
        else if (!oct3_reg.dx_neg)
        begin
            dir_next = oct3_reg.steep ? BASE_RD_STEEP - r8 : BASE_RD_FLAT + r8;
        end
        else if (!oct3_reg.dy_neg)
        begin
            dir_next = oct3_reg.steep ? r8 - DIR_DOWN : DIR_LEFT - r8;
        end
        else
        begin
            dir_next = oct3_reg.steep ? BASE_LU_STEEP - r8 : r8 - BASE_LU_FLAT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= div_out_valid;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (rdy2 && v1_reg)
        begin
            larger_reg  <= larger_next;
            smaller_reg <= smaller_next;
            oct2_reg    <= oct_next;
        end
        if (rdy3 && div_out_valid)
        begin
            prod_reg <= prod_next;
            oct3_reg <= div_oct;
        end
        if (rdy4 && v3_reg)
        begin
            dir_reg <= dir_next;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = dir_reg;

endmodule

### hw/rtl/bafp_div.sv
// ============================================================================
// bafp_div
// Pipelined restoring divider: quotient of 2^(QUOT_W-1) by a 16-bit divisor,
// BITS_PER_STAGE quotient bits per stage, with a side word carried alongside.
// ============================================================================
module bafp_div #(
    parameter int BITS_PER_STAGE = bafp_pkg::DIV_BPS_DEFAULT,
    parameter int SIDE_W         = bafp_pkg::SIDE_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bafp_pkg::MAG_W-1:0]  in_divisor,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bafp_pkg::QUOT_W-1:0] out_quot,
    output logic [SIDE_W-1:0]           out_side
);

    import bafp_pkg::*;

    localparam int NS = (QUOT_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

    logic [NS-1:0]       valid_reg;
    logic [NS:0]         rdy;
    logic [NS:0]         d_valid;
    logic [MAG_W-1:0]    d_rem  [0:NS];
    logic [QUOT_W-1:0]   d_quot [0:NS];
    logic [MAG_W-1:0]    d_div  [0:NS];
    logic [SIDE_W-1:0]   d_side [0:NS];

    assign d_valid[0] = in_valid;
    assign d_rem[0]   = '0;
    assign d_quot[0]  = '0;
    assign d_div[0]   = in_divisor;
    assign d_side[0]  = in_side;
    assign rdy[NS]    = out_ready;
    assign in_ready   = rdy[0];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [MAG_W-1:0]  rem_reg;
        logic [MAG_W-1:0]  rem_next;
        logic [QUOT_W-1:0] quot_reg;
        logic [QUOT_W-1:0] quot_next;
        logic [MAG_W-1:0]  div_reg;
        logic [SIDE_W-1:0] side_reg;
        logic [MAG_W:0]    trial;

        always_comb
        begin
            rem_next  = d_rem[s];
            quot_next = d_quot[s];
            trial     = '0;
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                if (s * BITS_PER_STAGE + j < QUOT_W)
                begin
                    trial = {rem_next, 1'(s * BITS_PER_STAGE + j == 0)};
                    if (trial >= {1'b0, d_div[s]})
                    begin
                        rem_next  = MAG_W'(trial - {1'b0, d_div[s]});
                        quot_next = {quot_next[QUOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = trial[MAG_W-1:0];
                        quot_next = {quot_next[QUOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        assign rdy[s] = !valid_reg[s] || rdy[s+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                valid_reg[s] <= d_valid[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && d_valid[s])
            begin
                rem_reg  <= rem_next;
                quot_reg <= quot_next;
                div_reg  <= d_div[s];
                side_reg <= d_side[s];
            end
        end

        assign d_valid[s+1] = valid_reg[s];
        assign d_rem[s+1]   = rem_reg;
        assign d_quot[s+1]  = quot_reg;
        assign d_div[s+1]   = div_reg;
        assign d_side[s+1]  = side_reg;
    end

    assign out_valid = d_valid[NS];
    assign out_quot  = d_quot[NS];
    assign out_side  = d_side[NS];

endmodule
